FILE: src/bitq_pkg.sv
package bitq_pkg;

    localparam int Z_BINS_DEF       = 8;
    localparam int PHI_BINS_DEF     = 8;
    localparam int MAX_CLUSTERS_DEF = 4096;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;
    localparam int CFG_W     = 16;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic REG_LAYER_HALF_Z = 1'b0;
    localparam logic REG_Z_BIN_SCALE  = 1'b1;

    localparam logic [14:0] LAYER_HALF_Z_RST = 15'd1024;
    localparam logic [15:0] Z_BIN_SCALE_RST  = 16'd256;

    typedef struct packed {
        logic        req_type;
        logic [5:0]  cluster_bin;
        logic        cluster_last;
        logic [15:0] z_min;
        logic [15:0] z_max;
        logic [15:0] phi_min;
        logic [15:0] phi_max;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_QZLO,
        ST_QZHI,
        ST_WALK,
        ST_CHECK,
        ST_FINISH
    } state_t;

endpackage

FILE: src/bitq_front.sv
module bitq_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bitq_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tuser,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output bitq_pkg::cmd_t                    cmd
);

    bitq_pkg::cmd_t q_reg [2];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    bitq_pkg::cmd_t in_cmd;
    logic           push, pop;

    // unpack the word into a command
    always_comb
    begin
        in_cmd.req_type     = s_tuser;
        in_cmd.cluster_bin  = s_tdata[5:0];
        in_cmd.cluster_last = s_tlast;
        in_cmd.z_min        = s_tdata[21:6];
        in_cmd.z_max        = s_tdata[37:22];
        in_cmd.phi_min      = s_tdata[53:38];
        in_cmd.phi_max      = s_tdata[69:54];
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

FILE: src/bitq_back.sv
module bitq_back #(
    parameter int Z_BINS       = bitq_pkg::Z_BINS_DEF,
    parameter int PHI_BINS     = bitq_pkg::PHI_BINS_DEF,
    parameter int MAX_CLUSTERS = bitq_pkg::MAX_CLUSTERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  bitq_pkg::cmd_t                    cmd,
    input  logic [14:0]                       layer_half_z,
    input  logic [15:0]                       z_bin_scale,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bitq_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    localparam int NBINS  = Z_BINS * PHI_BINS;
    localparam int ADDR_W = $clog2(NBINS + 1);
    localparam int PTR_W  = $clog2(NBINS + 2);
    localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
    localparam int ZB_W   = (Z_BINS > 1) ? $clog2(Z_BINS) : 1;
    localparam int PB_W   = (PHI_BINS > 1) ? $clog2(PHI_BINS) : 1;
    localparam int PN_W   = $clog2(PHI_BINS + 1);

    logic [CNT_W-1:0] mem [NBINS + 1];
    logic [CNT_W-1:0] rd0_reg, rd1_reg;

    bitq_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [PTR_W-1:0]  end_reg, end_next;
    logic [CNT_W-1:0]  val_reg, val_next;
    logic              lastpend_reg, lastpend_next;
    logic [15:0]       zmin_reg, zmin_next;
    logic [15:0]       zmax_reg, zmax_next;
    logic [15:0]       phimin_reg, phimin_next;
    logic [15:0]       phimax_reg, phimax_next;
    logic [15:0]       zlo_reg, zlo_next;
    logic [ZB_W-1:0]   zhi_reg, zhi_next;
    logic [PB_W-1:0]   pcur_reg, pcur_next;
    logic [ZB_W-1:0]   zcur_reg, zcur_next;
    logic [PN_W-1:0]   prem_reg, prem_next;
    logic [ADDR_W-1:0] curb_reg, curb_next;
    logic              final_reg, final_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_bin_reg, pend_bin_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_bin_reg, out_bin_next;
    logic              out_last_reg, out_last_next;
    logic              out_none_reg, out_none_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr0, rd_addr1;

    logic              out_free;
    logic [ADDR_W-1:0] cb_sat;
    logic signed [16:0] zmin17, zmax17, half17, zsum;
    logic [31:0]       prod;
    logic [15:0]       zhi_c;
    logic [PB_W-1:0]   plo, phi_hi;
    logic [PN_W-1:0]   pnum;
    int                pdiff;
    logic [ADDR_W-1:0] walk_b;
    logic              hit;

    assign cmd_ready = (state_reg == bitq_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, 6'(out_bin_reg)};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_none_reg;

    // shared z bin multiplier: low bound in QZLO, high bound in QZHI
    always_comb
    begin
        zmin17 = 17'(signed'(zmin_reg));
        zmax17 = 17'(signed'(zmax_reg));
        half17 = signed'({2'b00, layer_half_z});
        zsum   = ((state_reg == bitq_pkg::ST_QZLO) ? zmin17 : zmax17) + half17;
        prod   = 32'(zsum[15:0]) * 32'(z_bin_scale);
        cb_sat = (32'(cmd.cluster_bin) >= NBINS) ? ADDR_W'(NBINS - 1)
                                                 : ADDR_W'(cmd.cluster_bin);
        zhi_c  = (prod[31:16] > 16'(Z_BINS - 1)) ? 16'(Z_BINS - 1) : prod[31:16];
        plo    = PB_W'((32'(phimin_reg) * PHI_BINS) >> 16);
        phi_hi = PB_W'((32'(phimax_reg) * PHI_BINS) >> 16);
        pdiff  = int'(phi_hi) - int'(plo) + 1;
        if (pdiff < 0)
        begin
            pdiff = pdiff + PHI_BINS;
        end
        pnum   = PN_W'(pdiff);
        walk_b = ADDR_W'(int'(pcur_reg) * Z_BINS + int'(zcur_reg));
        hit    = (rd0_reg != rd1_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        prev_next       = prev_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        val_next        = val_reg;
        lastpend_next   = lastpend_reg;
        zmin_next       = zmin_reg;
        zmax_next       = zmax_reg;
        phimin_next     = phimin_reg;
        phimax_next     = phimax_reg;
        zlo_next        = zlo_reg;
        zhi_next        = zhi_reg;
        pcur_next       = pcur_reg;
        zcur_next       = zcur_reg;
        prem_next       = prem_reg;
        curb_next       = curb_reg;
        final_next      = final_reg;
        pend_valid_next = pend_valid_reg;
        pend_bin_next   = pend_bin_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_bin_next    = out_bin_reg;
        out_last_next   = out_last_reg;
        out_none_next   = out_none_reg;
        mem_we          = 1'b0;
        mem_waddr       = ADDR_W'(ptr_reg);
        mem_wdata       = val_reg;
        rd_en           = 1'b0;
        rd_addr0        = walk_b;
        rd_addr1        = walk_b + 1'b1;

        case (state_reg)
            bitq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.req_type == bitq_pkg::REQ_LOAD)
                    begin
                        ptr_next = PTR_W'(1);
                        end_next = '0;
                        if (cnt_reg < CNT_W'(MAX_CLUSTERS))
                        begin
                            if (cnt_reg == '0)
                            begin
                                ptr_next  = '0;
                                end_next  = '0;
                                val_next  = '0;
                                prev_next = '0;
                            end
                            else if (cb_sat > prev_reg)
                            begin
                                ptr_next  = PTR_W'(prev_reg) + 1'b1;
                                end_next  = PTR_W'(cb_sat);
                                val_next  = cnt_reg;
                                prev_next = cb_sat;
                            end
                            cnt_next = cnt_reg + 1'b1;
                        end
                        lastpend_next = cmd.cluster_last;
                        state_next    = bitq_pkg::ST_FILL;
                    end
                    else
                    begin
                        zmin_next   = cmd.z_min;
                        zmax_next   = cmd.z_max;
                        phimin_next = cmd.phi_min;
                        phimax_next = cmd.phi_max;
                        state_next  = bitq_pkg::ST_QZLO;
                    end
                end
            end

            bitq_pkg::ST_FILL:
            begin
                if (ptr_reg <= end_reg)
                begin
                    mem_we   = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (lastpend_reg)
                begin
                    // close the load: run the tail up to the end entry
                    ptr_next      = PTR_W'(prev_reg) + 1'b1;
                    end_next      = PTR_W'(NBINS);
                    val_next      = cnt_reg;
                    prev_next     = '0;
                    cnt_next      = '0;
                    lastpend_next = 1'b0;
                end
                else
                begin
                    state_next = bitq_pkg::ST_IDLE;
                end
            end

            bitq_pkg::ST_QZLO:
            begin
                if (zmax17 < -half17 || zmin17 > half17 || zmin17 > zmax17)
                begin
                    state_next = bitq_pkg::ST_FINISH;
                end
                else
                begin
                    zlo_next   = zsum[16] ? 16'd0 : prod[31:16];
                    state_next = bitq_pkg::ST_QZHI;
                end
            end

            bitq_pkg::ST_QZHI:
            begin
                if (zlo_reg > zhi_c || pnum == '0)
                begin
                    state_next = bitq_pkg::ST_FINISH;
                end
                else
                begin
                    zhi_next   = ZB_W'(zhi_c);
                    zcur_next  = ZB_W'(zlo_reg);
                    pcur_next  = plo;
                    prem_next  = pnum;
                    state_next = bitq_pkg::ST_WALK;
                end
            end

            bitq_pkg::ST_WALK:
            begin
                rd_en      = 1'b1;
                curb_next  = walk_b;
                final_next = (prem_reg == PN_W'(1)) && (zcur_reg == zhi_reg);
                if (zcur_reg == zhi_reg)
                begin
                    zcur_next = ZB_W'(zlo_reg);
                    pcur_next = (pcur_reg == PB_W'(PHI_BINS - 1)) ? '0 : pcur_reg + 1'b1;
                    prem_next = prem_reg - 1'b1;
                end
                else
                begin
                    zcur_next = zcur_reg + 1'b1;
                end
                state_next = bitq_pkg::ST_CHECK;
            end

            bitq_pkg::ST_CHECK:
            begin
                // hold a hit back one step so the final one can carry last
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_bin_next   = pend_bin_reg;
                            out_last_next  = 1'b0;
                            out_none_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_bin_next   = curb_reg;
                    end
                    state_next = final_reg ? bitq_pkg::ST_FINISH : bitq_pkg::ST_WALK;
                end
            end

            bitq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_none_next   = !pend_valid_reg;
                    out_bin_next    = pend_valid_reg ? pend_bin_reg : '0;
                    pend_valid_next = 1'b0;
                    state_next      = bitq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bitq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bitq_pkg::ST_IDLE;
            prev_reg       <= '0;
            cnt_reg        <= '0;
            lastpend_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_reg       <= prev_next;
            cnt_reg        <= cnt_next;
            lastpend_reg   <= lastpend_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        end_reg      <= end_next;
        val_reg      <= val_next;
        zmin_reg     <= zmin_next;
        zmax_reg     <= zmax_next;
        phimin_reg   <= phimin_next;
        phimax_reg   <= phimax_next;
        zlo_reg      <= zlo_next;
        zhi_reg      <= zhi_next;
        pcur_reg     <= pcur_next;
        zcur_reg     <= zcur_next;
        prem_reg     <= prem_next;
        curb_reg     <= curb_next;
        final_reg    <= final_next;
        pend_bin_reg <= pend_bin_next;
        out_bin_reg  <= out_bin_next;
        out_last_reg <= out_last_next;
        out_none_reg <= out_none_next;
    end

    // start table: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd0_reg <= mem[rd_addr0];
            rd1_reg <= mem[rd_addr1];
        end
    end

endmodule

FILE: src/binned_index_table_range_query_top.sv
// Channel   Dir  tdata (low bit up)                              tlast         tuser
// s_axis    in   cluster_bin, z_min, z_max, phi_min, phi_max, 0  cluster_last  req_type
// m_axis    out  bin_index, 0                                    last          none_found
// cfg       in   cfg_addr 0 layer_half_z, 1 z_bin_scale; cfg_wdata, cfg_we
//
// A load word fills its table entries one per cycle through the single
// table write port; the last load word then runs the tail up to the end
// entry. A query whose z range misses the layer, or whose window is empty,
// ends without a walk; any other query walks the bins in its window, each
// with a start table read and then a compare; a stalled output holds the
// walk sequencer.
// Reset clears the sequencer, the load count and the output valid; the
// start table is not cleared. A two-word queue in front keeps s_tready up
// while the back end works or the output stalls, until it holds two words.
module binned_index_table_range_query_top #(
    parameter int Z_BINS       = bitq_pkg::Z_BINS_DEF,
    parameter int PHI_BINS     = bitq_pkg::PHI_BINS_DEF,
    parameter int MAX_CLUSTERS = bitq_pkg::MAX_CLUSTERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cluster_bin[5:0], z_min[21:6], z_max[37:22], phi_min[53:38], phi_max[69:54]
    input  logic [bitq_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    // req_type
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bin_index[5:0]
    output logic [bitq_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    // none_found
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [bitq_pkg::CFG_W-1:0]        cfg_wdata
);

    logic           cmd_valid;
    logic           cmd_ready;
    bitq_pkg::cmd_t cmd;
    logic [14:0]    layer_half_z_reg;
    logic [15:0]    z_bin_scale_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_half_z_reg <= bitq_pkg::LAYER_HALF_Z_RST;
            z_bin_scale_reg  <= bitq_pkg::Z_BIN_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bitq_pkg::REG_LAYER_HALF_Z: layer_half_z_reg <= cfg_wdata[14:0];
                bitq_pkg::REG_Z_BIN_SCALE:  z_bin_scale_reg  <= cfg_wdata;
                default:                    z_bin_scale_reg  <= z_bin_scale_reg;
            endcase
        end
    end

    // front: accept words and queue them
    bitq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back: build the start table, walk query windows
    bitq_back #(
        .Z_BINS       (Z_BINS),
        .PHI_BINS     (PHI_BINS),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .layer_half_z (layer_half_z_reg),
        .z_bin_scale  (z_bin_scale_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule

FILE: src/bitq_checker.sv
module bitq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bitq_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              m_tlast,
    input logic                              m_tuser
);

    // an empty query gives a single word
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("none_found word without last");

    a_none_zero_bin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("none_found word with nonzero bin");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

endmodule

bind binned_index_table_range_query_top bitq_checker u_bitq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
